// File: rtl/ctpbr_pkg.sv
package ctpbr_pkg;

  localparam int INDEX_BITS  = 8;
  localparam int COOKIE_BITS = 24;
  localparam int SLOTS       = 256;
  localparam int HANDLE_BITS = 32;

  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int ID_BITS   = 32;
  localparam int HOLD_BITS = 16;
  localparam int TICK_BITS = 32;

  localparam logic [INDEX_BITS:0] SLOT_LIMIT = (INDEX_BITS + 1)'(SLOTS);
  localparam logic [HOLD_BITS-1:0] HOLD_RESET = HOLD_BITS'(1000);

  localparam logic [2:0] REQ_TICK        = 3'd0;
  localparam logic [2:0] REQ_SAVE        = 3'd1;
  localparam logic [2:0] REQ_RETRIEVE    = 3'd2;
  localparam logic [2:0] REQ_DISCARD     = 3'd3;
  localparam logic [2:0] REQ_DISCARD_ALL = 3'd4;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_DELIVER = 2'd1;
  localparam logic [1:0] KIND_FREE    = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] packet_handle;
    logic [31:0] target_id;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] assigned_id;
    logic [1:0]  handle_kind;
    logic [31:0] handle_out;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } dp_status_t;

endpackage

// File: rtl/ctpbr_ctrl.sv
module ctpbr_ctrl
  import ctpbr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  assign in_ready    = (state == ST_IDLE) && !rst;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.commit  = (state == ST_EXEC) && !status.out_blocked;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.capture) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_capture_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == ST_EXEC)
    else $error("Accepted transaction did not enter the execute state.");

  a_commit_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> state == ST_IDLE)
    else $error("Controller did not return to idle after a commit.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && status.out_blocked) |=> state == ST_EXEC)
    else $error("Controller left the execute state while the output was blocked.");

endmodule

// File: rtl/ctpbr_datapath.sv
module ctpbr_datapath
  import ctpbr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           status,
  input  req_t                 in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rsp_t                 out_data,
  input  logic                 cfg_valid,
  input  logic [HOLD_BITS-1:0] cfg_data
);

  logic [HOLD_BITS-1:0]   hold_ticks;
  logic [INDEX_BITS-1:0]  ring_index;
  logic [TICK_BITS-1:0]   tick_count;
  logic [SLOTS-1:0]       occupied;
  logic [SLOTS-1:0]       cookie_written;

  logic [COOKIE_BITS-1:0] cookie_mem [SLOTS];
  logic [HANDLE_BITS-1:0] handle_mem [SLOTS];
  logic [TICK_BITS-1:0]   expiry_mem [SLOTS];

  req_t                   item_q;
  logic [INDEX_BITS-1:0]  sel_idx_q;
  logic [SLOT_BITS-1:0]   addr_q;
  logic                   idx_ok_q;
  logic                   occ_q;
  logic                   cookie_vld_q;
  logic [COOKIE_BITS-1:0] cookie_rd;
  logic [HANDLE_BITS-1:0] handle_rd;
  logic [TICK_BITS-1:0]   expiry_rd;

  logic [INDEX_BITS-1:0]  ring_inc;
  logic [INDEX_BITS-1:0]  ring_next;
  logic [INDEX_BITS-1:0]  sel_idx;
  logic [SLOT_BITS-1:0]   addr_c;
  logic                   idx_ok;

  logic [COOKIE_BITS-1:0] cookie_cur;
  logic [COOKIE_BITS-1:0] cookie_inc;
  logic [COOKIE_BITS-1:0] cookie_new;
  logic [TICK_BITS-1:0]   hold_diff;
  logic                   save_refused;
  logic                   tag_match;
  logic                   hit;
  logic                   is_save;
  logic                   save_store;
  logic                   release_slot;
  rsp_t                   rsp;

  assign ring_inc  = ring_index + 1'b1;
  assign ring_next = ({1'b0, ring_inc} >= SLOT_LIMIT) ? '0 : ring_inc;
  assign sel_idx   = (in_data.req_type == REQ_SAVE) ? ring_next
                                                    : in_data.target_id[INDEX_BITS-1:0];
  assign idx_ok    = (in_data.req_type == REQ_SAVE) || ({1'b0, sel_idx} < SLOT_LIMIT);
  assign addr_c    = sel_idx[SLOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q       <= in_data;
      sel_idx_q    <= sel_idx;
      addr_q       <= addr_c;
      idx_ok_q     <= idx_ok;
      occ_q        <= occupied[addr_c];
      cookie_vld_q <= cookie_written[addr_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && save_store) begin
      cookie_mem[addr_q] <= cookie_new;
    end
    if (cmd.capture) begin
      cookie_rd <= cookie_mem[addr_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && save_store) begin
      handle_mem[addr_q] <= HANDLE_BITS'(item_q.packet_handle);
    end
    if (cmd.capture) begin
      handle_rd <= handle_mem[addr_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && save_store) begin
      expiry_mem[addr_q] <= tick_count + TICK_BITS'(hold_ticks);
    end
    if (cmd.capture) begin
      expiry_rd <= expiry_mem[addr_c];
    end
  end

  assign cookie_cur   = cookie_vld_q ? cookie_rd : '0;
  assign cookie_inc   = cookie_cur + 1'b1;
  assign cookie_new   = (cookie_inc == '1) ? '0 : cookie_inc;
  assign hold_diff    = tick_count - expiry_rd;
  assign save_refused = occ_q && hold_diff[TICK_BITS-1];
  assign is_save      = (item_q.req_type == REQ_SAVE);
  assign save_store   = is_save && !save_refused;
  assign tag_match    = ((item_q.target_id >> INDEX_BITS) == 32'(cookie_cur));
  assign hit          = idx_ok_q && tag_match && occ_q;
  assign release_slot = ((item_q.req_type == REQ_RETRIEVE)
                         || (item_q.req_type == REQ_DISCARD)) && hit;

  always_comb begin
    rsp = '0;
    case (item_q.req_type)
      REQ_SAVE: begin
        if (save_refused) begin
          rsp.assigned_id = '1;
        end else begin
          rsp.ok          = 1'b1;
          rsp.assigned_id = ID_BITS'({cookie_new, sel_idx_q});
          if (occ_q) begin
            rsp.handle_kind = KIND_FREE;
            rsp.handle_out  = 32'(handle_rd);
          end
        end
      end
      REQ_RETRIEVE, REQ_DISCARD: begin
        if (hit) begin
          rsp.ok          = 1'b1;
          rsp.handle_kind = (item_q.req_type == REQ_RETRIEVE) ? KIND_DELIVER : KIND_FREE;
          rsp.handle_out  = 32'(handle_rd);
        end
      end
      default: rsp = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks     <= HOLD_RESET;
      ring_index     <= '0;
      tick_count     <= '0;
      occupied       <= '0;
      cookie_written <= '0;
    end else begin
      if (cfg_valid) begin
        hold_ticks <= cfg_data;
      end
      if (cmd.commit) begin
        if (is_save) begin
          ring_index <= sel_idx_q;
        end
        if (save_store) begin
          occupied[addr_q]       <= 1'b1;
          cookie_written[addr_q] <= 1'b1;
        end
        if (release_slot) begin
          occupied[addr_q] <= 1'b0;
        end
        if (item_q.req_type == REQ_DISCARD_ALL) begin
          occupied <= '0;
        end
        if (item_q.req_type == REQ_TICK) begin
          tick_count <= tick_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= rsp;
    end
  end

  assign status.out_blocked = out_valid && !out_ready;

  a_commit_loads_output: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("Committed transaction did not load the output register.");

  a_save_marks_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && save_store) |=> occupied[$past(addr_q)])
    else $error("Stored save left its slot empty.");

  a_release_clears_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && release_slot) |=> !occupied[$past(addr_q)])
    else $error("Retrieve or discard left its slot occupied.");

endmodule

// File: rtl/cookie_tagged_packet_buffer_ring.sv
// A ring of packet-handle slots, each tagged with a generation cookie. Save advances the
// ring index and stores the handle unless the slot is still within its hold time; it returns
// an id of slot index plus cookie and reports any evicted handle for freeing. Retrieve and
// discard check the cookie and empty the slot, discard-all empties every slot without
// reporting handles, and tick advances the time counter. The slot memories are read on
// acceptance and the slot is rewritten while the result is registered, one transaction at
// a time, held while the output is blocked. The output register lets the next transaction be
// accepted while a result waits. No clearing pass follows reset. The hold-time register may
// be written only while no transaction is in progress.
module cookie_tagged_packet_buffer_ring
  import ctpbr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  req_t                 in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rsp_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [HOLD_BITS-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = !rst;

  ctpbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ctpbr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data)
  );

endmodule

// File: dv/tb_cookie_tagged_packet_buffer_ring.sv
module tb_cookie_tagged_packet_buffer_ring;
  import ctpbr_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 150;
  localparam int LIVE_ID_CAP = 64;
  localparam logic [2:0] REQ_UNUSED_LO = REQ_DISCARD_ALL + 3'd1;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  class slot_ring_sb;
    logic occupied [SLOTS];
    logic [COOKIE_BITS-1:0] cookie [SLOTS];
    logic [TICK_BITS-1:0] expiry [SLOTS];
    logic [31:0] handle [SLOTS];
    int ring_idx;
    logic [TICK_BITS-1:0] ticks;
    logic [HOLD_BITS-1:0] hold;
    rsp_t rsp_owed [$];
    logic [31:0] live_ids [$];
    logic [31:0] last_id;
    int errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        occupied[i] = 1'b0;
        cookie[i] = '0;
        expiry[i] = '0;
        handle[i] = '0;
      end
      ring_idx = 0;
      ticks = '0;
      hold = HOLD_RESET;
      last_id = '0;
      errors = 0;
    endfunction

    function void set_hold(logic [HOLD_BITS-1:0] v);
      hold = v;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int idx;
      logic [TICK_BITS-1:0] since;
      logic [COOKIE_BITS-1:0] c;
      logic [31:0] tag;
      e = '0;
      case (r.req_type)
        REQ_TICK: ticks = ticks + 1'b1;
        REQ_SAVE: begin
          idx = (ring_idx + 1) % (1 << INDEX_BITS);
          if (idx >= SLOTS) idx = 0;
          ring_idx = idx;
          since = ticks - expiry[idx];
          if (occupied[idx] && since[TICK_BITS-1]) begin
            e.assigned_id = '1;
          end else begin
            if (occupied[idx]) begin
              e.handle_kind = KIND_FREE;
              e.handle_out = handle[idx];
            end
            c = cookie[idx] + 1'b1;
            if (&c) c = '0;
            cookie[idx] = c;
            occupied[idx] = 1'b1;
            handle[idx] = r.packet_handle;
            expiry[idx] = ticks + TICK_BITS'(hold);
            e.ok = 1'b1;
            e.assigned_id = 32'(idx) | (32'(c) << INDEX_BITS);
            last_id = e.assigned_id;
            live_ids.push_back(e.assigned_id);
            if (live_ids.size() > LIVE_ID_CAP) void'(live_ids.pop_front());
          end
        end
        REQ_RETRIEVE, REQ_DISCARD: begin
          idx = int'(r.target_id[INDEX_BITS-1:0]);
          tag = r.target_id >> INDEX_BITS;
          if (idx < SLOTS && 32'(cookie[idx]) == tag && occupied[idx]) begin
            e.ok = 1'b1;
            e.handle_kind = (r.req_type == REQ_RETRIEVE) ? KIND_DELIVER : KIND_FREE;
            e.handle_out = handle[idx];
            occupied[idx] = 1'b0;
          end
        end
        REQ_DISCARD_ALL: begin
          for (int i = 0; i < SLOTS; i++) occupied[i] = 1'b0;
        end
        default: ;
      endcase
      rsp_owed.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (rsp_owed.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: ok=%0d id=%h kind=%0d handle=%h",
                   got.ok, got.assigned_id, got.handle_kind, got.handle_out);
        return;
      end
      e = rsp_owed.pop_front();
      if (got.ok !== e.ok || got.assigned_id !== e.assigned_id ||
          got.handle_kind !== e.handle_kind || got.handle_out !== e.handle_out) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %0d %h %0d %h, actual %0d %h %0d %h",
                   e.ok, e.assigned_id, e.handle_kind, e.handle_out,
                   got.ok, got.assigned_id, got.handle_kind, got.handle_out);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [HOLD_BITS-1:0] cfg_data = '0;

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int cycle_count = 0;
  slot_ring_sb sb;

  cookie_tagged_packet_buffer_ring DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_response(out_data);
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic req_t mk(logic [2:0] rt, logic [31:0] h, logic [31:0] b);
    req_t r;
    r.req_type = rt;
    r.packet_handle = h;
    r.target_id = b;
    return r;
  endfunction

  task automatic send_req(input req_t r);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.rsp_owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_hold(input logic [HOLD_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_hold(v);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t random_req(bit allow_clear);
    req_t r;
    int pick;
    logic [31:0] id;
    r = mk(REQ_SAVE, $urandom(), $urandom());
    pick = $urandom_range(99);
    if (pick < 22) begin
      r.req_type = REQ_TICK;
    end else if (pick < 77) begin
      r.req_type = REQ_SAVE;
    end else if (pick < 93) begin
      r.req_type = (pick < 86) ? REQ_RETRIEVE : REQ_DISCARD;
      if (sb.live_ids.size() != 0) begin
        id = sb.live_ids[$urandom_range(sb.live_ids.size() - 1)];
        if ($urandom_range(4) == 0) id = id ^ (32'h1 << $urandom_range(31, INDEX_BITS));
        r.target_id = id;
      end
    end else if (pick < 96) begin
      r.req_type = 3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
    end else if (pick == 99 && allow_clear) begin
      r.req_type = REQ_DISCARD_ALL;
    end else begin
      r.req_type = 3'($urandom_range(7));
      if (!allow_clear && r.req_type == REQ_DISCARD_ALL) r.req_type = REQ_TICK;
    end
    return r;
  endfunction

  task automatic directed();
    logic [31:0] id_a, id_b, id_c;
    send_req(mk(REQ_RETRIEVE, 32'h0, 32'h0));
    send_req(mk(REQ_SAVE, 32'h0, 32'hFFFF_FFFF));
    id_a = sb.last_id;
    send_req(mk(REQ_SAVE, 32'hFFFF_FFFF, 32'h0));
    id_b = sb.last_id;
    send_req(mk(REQ_SAVE, 32'hA5A5_5A5A, 32'h0));
    id_c = sb.last_id;
    send_req(mk(REQ_RETRIEVE, 32'hFFFF_FFFF, id_a));
    send_req(mk(REQ_RETRIEVE, 32'h0, id_a));
    send_req(mk(REQ_DISCARD, 32'h0, id_b ^ 32'h0000_0100));
    send_req(mk(REQ_DISCARD, 32'h0, id_b));
    send_req(mk(REQ_RETRIEVE, 32'h0, 32'hFFFF_FFFF));
    send_req(mk(REQ_DISCARD, 32'h0, {COOKIE_BITS'($urandom_range(32'hFF_FFFF)),
                                     id_c[INDEX_BITS-1:0]}));
    send_req(mk(REQ_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_req(mk(REQ_TICK, 32'h0, 32'h0));
    for (int t = REQ_UNUSED_LO; t <= REQ_UNUSED_HI; t++)
      send_req(mk(3'(t), $urandom(), $urandom()));
    send_req(mk(REQ_DISCARD_ALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_req(mk(REQ_RETRIEVE, 32'h0, id_c));
    send_req(mk(REQ_SAVE, 32'h1234_5678, 32'hFFFF_FFFF));
    send_req(mk(REQ_DISCARD, 32'h0, sb.last_id));
    send_req(mk(REQ_RETRIEVE, 32'h0, 32'h0));
  endtask

  initial begin
    logic [HOLD_BITS-1:0] holds [PHASES];
    int idle_in [4];
    int stall_out [4];
    holds = '{16'd0, 16'd1, 16'd40, 16'hFFFF, 16'd3, 16'd1000, 16'd0};
    idle_in = '{0, 62, 0, 15};
    stall_out = '{0, 0, 62, 15};
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    directed();
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_hold(holds[p]);
      in_idle_pct = idle_in[p % 4];
      out_stall_pct = stall_out[p % 4];
      for (int i = 0; i < PHASE_ITEMS; i++) send_req(random_req(p == 2 || p == 5));
    end
    settle();
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.rsp_owed.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ctpbr_pkg.sv
rtl/ctpbr_ctrl.sv
rtl/ctpbr_datapath.sv
rtl/cookie_tagged_packet_buffer_ring.sv
dv/tb_cookie_tagged_packet_buffer_ring.sv
